>>> hw/rtl/utf8_stream_validator_defines.svh
// Assertion macros used by the top-level validator RTL.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Implication checked on every rising edge, masked while reset is asserted.
`define U8SV_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked in the cycle after its antecedent.
`define U8SV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define U8SV_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

>>> hw/rtl/u8sv_pkg.sv
`default_nettype none

package u8sv_pkg;

  // Default depth of the token queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Byte patterns.
  localparam logic [7:0] ASCII_MAX   = 8'h7f;
  localparam logic [7:0] MASK_LEAD2  = 8'he0;
  localparam logic [7:0] PAT_LEAD2   = 8'hc0;
  localparam logic [7:0] MASK_LEAD3  = 8'hf0;
  localparam logic [7:0] PAT_LEAD3   = 8'he0;
  localparam logic [7:0] MASK_LEAD4  = 8'hf8;
  localparam logic [7:0] PAT_LEAD4   = 8'hf0;
  localparam logic [7:0] MASK_CONT   = 8'hc0;
  localparam logic [7:0] PAT_CONT    = 8'h80;
  localparam logic [7:0] LEAD_ED     = 8'hed;
  localparam logic [7:0] MASK_SURR   = 8'ha0;

  // Continuation counts owed after a lead byte.
  localparam logic [1:0] OWED_NONE  = 2'd0;
  localparam logic [1:0] OWED_ONE   = 2'd1;
  localparam logic [1:0] OWED_TWO   = 2'd2;
  localparam logic [1:0] OWED_THREE = 2'd3;

  // Classified byte, as handed from front to back.
  typedef struct packed {
    logic       cont_ok;    // byte matches 10xxxxxx
    logic       surr_bits;  // bits 7 and 5 both set
    logic       lead_bad;   // byte matches no lead pattern
    logic [1:0] lead_owed;  // continuations owed if taken as a lead
    logic       lead_ed;    // byte is the 0xED lead
    logic       last;       // last byte of the string
  } tok_t;

endpackage

`default_nettype wire

>>> hw/rtl/utf8_stream_validator.sv
//  Channel  | Ports                                 | Handshake
//  ---------+---------------------------------------+--------------------------
//  input    | in_data_byte[7:0], in_end_of_string   | in_push, in_full
//  result   | out_string_valid                      | out_empty, out_pop
//
//  One byte per cycle sustained, set by the back end's per-byte state update, while
//  no final byte awaits an unpopped verdict. A verdict registers as its last byte is taken.
//  Reset is synchronous on rst_n and clears the state and all queued items.
//  While a verdict is unpopped the back end holds at the next final byte;
//  in_full rises once QUEUE_DEPTH classified bytes wait in the queue.
`default_nettype none

`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator #(
  parameter int unsigned QUEUE_DEPTH = u8sv_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_string,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_string_valid
);
  import u8sv_pkg::*;

  tok_t front_tok;   // classified byte from the front end
  tok_t head_tok;    // oldest classified byte waiting for the back end
  logic q_empty;
  logic tok_take;

  // Classify each incoming byte as a lead or a continuation candidate.
  u8sv_front u_front (
    .data_byte     (in_data_byte),
    .end_of_string (in_end_of_string),
    .tok           (front_tok)
  );

  // Hold classified bytes so the front keeps taking items while a verdict waits.
  u8sv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_tok (front_tok),
    .full     (in_full),
    .pop      (tok_take),
    .head_tok (head_tok),
    .empty    (q_empty)
  );

  // Advance the owed count and error flag; register the verdict of each string.
  u8sv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (!q_empty),
    .tok              (head_tok),
    .tok_take         (tok_take),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_string_valid (out_string_valid)
  );

  `U8SV_ASSERT_IMPLY(a_take_needs_token, tok_take, !q_empty, "back end took from an empty queue")
  `U8SV_ASSERT_NEVER(a_full_and_empty, in_full && q_empty, "queue reports full and empty")
  `U8SV_ASSERT_NEXT(a_push_fills_queue, in_push && !in_full, !q_empty, "accepted item lost")

endmodule

`default_nettype wire

>>> hw/rtl/u8sv_front.sv
`default_nettype none

module u8sv_front (
  input  logic [7:0]     data_byte,
  input  logic           end_of_string,
  output u8sv_pkg::tok_t tok
);
  import u8sv_pkg::*;

  always_comb begin
    tok           = '0;
    tok.cont_ok   = (data_byte & MASK_CONT) == PAT_CONT;
    tok.surr_bits = (data_byte & MASK_SURR) == MASK_SURR;
    tok.lead_ed   = data_byte == LEAD_ED;
    tok.last      = end_of_string;
    if (data_byte <= ASCII_MAX) begin
      tok.lead_owed = OWED_NONE;
    end else if ((data_byte & MASK_LEAD2) == PAT_LEAD2) begin
      tok.lead_owed = OWED_ONE;
    end else if ((data_byte & MASK_LEAD3) == PAT_LEAD3) begin
      tok.lead_owed = OWED_TWO;
    end else if ((data_byte & MASK_LEAD4) == PAT_LEAD4) begin
      tok.lead_owed = OWED_THREE;
    end else begin
      tok.lead_owed = OWED_NONE;
      tok.lead_bad  = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u8sv_queue.sv
`default_nettype none

module u8sv_queue #(
  parameter int unsigned DEPTH = u8sv_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8sv_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output u8sv_pkg::tok_t head_tok,
  output logic           empty
);
  import u8sv_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tok_t          entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_tok = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u8sv_back.sv
`default_nettype none

module u8sv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tok_valid,
  input  u8sv_pkg::tok_t tok,
  output logic           tok_take,
  output logic           out_empty,
  input  logic           out_pop,
  output logic           out_string_valid
);
  import u8sv_pkg::*;

  logic [1:0] owed_r, owed_nxt;
  logic       ed_r, ed_nxt;
  logic       err_r, err_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       res_r, res_nxt;

  // A non-final token needs no result slot; a final one waits for a free slot.
  assign tok_take = tok_valid && (!tok.last || !res_valid_r || out_pop);

  always_comb begin
    owed_nxt      = owed_r;
    ed_nxt        = ed_r;
    err_nxt       = err_r;
    res_valid_nxt = res_valid_r && !out_pop;
    res_nxt       = res_r;
    if (tok_take) begin
      err_nxt = err_r || (ed_r && tok.surr_bits);
      if (owed_r != OWED_NONE) begin
        if (!tok.cont_ok) begin
          err_nxt = 1'b1;
        end
        owed_nxt = owed_r - 1'b1;
        ed_nxt   = 1'b0;
      end else begin
        if (tok.lead_bad) begin
          err_nxt = 1'b1;
        end
        owed_nxt = tok.lead_owed;
        ed_nxt   = tok.lead_ed;
      end
      if (tok.last) begin
        res_valid_nxt = 1'b1;
        res_nxt       = !err_nxt && (owed_nxt == OWED_NONE);
        owed_nxt      = OWED_NONE;
        ed_nxt        = 1'b0;
        err_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r      <= OWED_NONE;
      ed_r        <= 1'b0;
      err_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      owed_r      <= owed_nxt;
      ed_r        <= ed_nxt;
      err_r       <= err_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_empty        = !res_valid_r;
  assign out_string_valid = res_r;

endmodule

`default_nettype wire
